@@ rtl/core/cip_logical_path_decoder_unit_assert.svh @@
// assertion macros for the logical path decoder
// clocked on clk, disabled while rst_n is low unless the name says otherwise
`ifndef CIP_LOGICAL_PATH_DECODER_UNIT_ASSERT_SVH
`define CIP_LOGICAL_PATH_DECODER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// property checked outside reset
`define CLDU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property checked during reset as well
`define CLDU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CLDU_ASSERT(label, prop, msg)
`define CLDU_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ rtl/core/cldu_pkg.sv @@
// shared widths, size codes and segment positions of the logical path decoder
// no dependencies
package cldu_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 3;

  // low two bits of a logical segment header
  typedef enum logic [1:0] {
    SZ_BYTE  = 2'd0,
    SZ_WORD  = 2'd1,
    SZ_DWORD = 2'd2,
    SZ_RSVD  = 2'd3
  } size_code_t;

  // byte positions within a segment
  localparam logic [POS_W-1:0] POS_HDR        = 3'd0;
  localparam logic [POS_W-1:0] POS_PAD        = 3'd1;
  localparam logic [POS_W-1:0] POS_VAL0       = 3'd2;
  localparam logic [POS_W-1:0] POS_LAST_WORD  = 3'd3;
  localparam logic [POS_W-1:0] POS_LAST_DWORD = 3'd5;

endpackage

@@ rtl/core/cldu_in_if.sv @@
// input byte channel of the logical path decoder
// depends on cldu_pkg
interface cldu_in_if import cldu_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] path_byte;
  logic              last_byte;

  modport source (output valid, output path_byte, output last_byte, input ready);
  modport sink   (input valid, input path_byte, input last_byte, output ready);
endinterface

@@ rtl/core/cldu_out_if.sv @@
// result channel of the logical path decoder
// depends on cldu_pkg
interface cldu_out_if import cldu_pkg::*;;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] seg_value;
  logic [BYTE_W-1:0]  seg_header;
  logic               has_value;
  logic               path_end;
  logic               malformed;

  modport source (output valid, output seg_value, output seg_header, output has_value,
                  output path_end, output malformed, input ready);
  modport sink   (input valid, input seg_value, input seg_header, input has_value,
                  input path_end, input malformed, output ready);
endinterface

@@ rtl/core/cip_logical_path_decoder_unit.sv @@
// Logical path segment decoder: takes one path byte per beat and decodes logical
// segments (8-bit, padded 16-bit and padded 32-bit little-endian values). Each
// completed segment gives one result beat with its value and header byte, and the
// final byte of a path always gives a result with path_end set; a reserved size
// code or a path cut off inside a segment flags that end beat malformed, and the
// decoder is back in its reset state for the next path. Throughput is one byte per
// clock while out_ch is not stalled. The segment state is registered and each result
// sits in one output register, valid in the cycle after its byte is accepted; that
// register may be drained in the same cycle a new byte is taken. Bytes that finish no
// segment and are not final produce no beat.
// depends on cldu_pkg, cldu_in_if, cldu_out_if, cip_logical_path_decoder_unit_assert.svh
`include "cip_logical_path_decoder_unit_assert.svh"

module cip_logical_path_decoder_unit import cldu_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  cldu_in_if.sink    in_ch,
  cldu_out_if.source out_ch
);

  // segment state
  logic [POS_W-1:0]   seg_pos_r,   seg_pos_nxt;
  logic [BYTE_W-1:0]  hdr_r,       hdr_nxt;
  logic [VALUE_W-1:0] value_acc_r, value_acc_nxt;
  logic               halted_r,    halted_nxt;

  // output register
  logic               out_vld_r, out_vld_nxt;
  logic [VALUE_W-1:0] seg_value_r;
  logic [BYTE_W-1:0]  seg_header_r;
  logic               has_value_r, path_end_r, malformed_r;

  logic               in_acc;
  logic               done;
  logic               emit;
  size_code_t         code;
  logic [1:0]         lane;
  logic [POS_W-1:0]   val_idx;

  // output register frees up when empty or drained this cycle
  assign in_ch.ready = !out_vld_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign code    = size_code_t'(hdr_r[1:0]);
  assign val_idx = seg_pos_r - POS_VAL0;
  assign lane    = val_idx[1:0];

  always_comb begin
    seg_pos_nxt   = seg_pos_r;
    hdr_nxt       = hdr_r;
    value_acc_nxt = value_acc_r;
    halted_nxt    = halted_r;
    done          = 1'b0;

    if (halted_r) begin
      // rest of the path is dropped
    end else if (seg_pos_r == POS_HDR) begin
      if (size_code_t'(in_ch.path_byte[1:0]) == SZ_RSVD) begin
        halted_nxt = 1'b1;
      end else begin
        hdr_nxt       = in_ch.path_byte;
        value_acc_nxt = '0;
        seg_pos_nxt   = POS_PAD;
      end
    end else begin
      if (code == SZ_BYTE) begin
        value_acc_nxt = {{(VALUE_W-BYTE_W){1'b0}}, in_ch.path_byte};
        done          = 1'b1;
      end else if (seg_pos_r >= POS_VAL0) begin
        // little-endian byte lanes, pad byte skipped
        value_acc_nxt = value_acc_r |
                        ({{(VALUE_W-BYTE_W){1'b0}}, in_ch.path_byte} << {lane, 3'b000});
        done = ((code == SZ_WORD)  && (seg_pos_r == POS_LAST_WORD)) ||
               ((code == SZ_DWORD) && (seg_pos_r == POS_LAST_DWORD));
      end
      seg_pos_nxt = done ? POS_HDR : seg_pos_r + 3'd1;
    end

    // a path end starts the next path from scratch
    if (in_ch.last_byte) begin
      seg_pos_nxt   = POS_HDR;
      hdr_nxt       = '0;
      value_acc_nxt = '0;
      halted_nxt    = 1'b0;
    end
  end

  assign emit = done || in_ch.last_byte;

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (in_acc) begin
      out_vld_nxt = emit;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_pos_r   <= POS_HDR;
      hdr_r       <= '0;
      value_acc_r <= '0;
      halted_r    <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (in_acc) begin
        seg_pos_r   <= seg_pos_nxt;
        hdr_r       <= hdr_nxt;
        value_acc_r <= value_acc_nxt;
        halted_r    <= halted_nxt;
      end
    end
  end

  // result payload, loaded only with a beat that produces a result
  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      if (done) begin
        // value taken before any end-of-path clear
        seg_value_r  <= (code == SZ_BYTE) ? {{(VALUE_W-BYTE_W){1'b0}}, in_ch.path_byte}
                                          : value_acc_r |
                        ({{(VALUE_W-BYTE_W){1'b0}}, in_ch.path_byte} << {lane, 3'b000});
        seg_header_r <= hdr_r;
        has_value_r  <= 1'b1;
        malformed_r  <= 1'b0;
      end else begin
        seg_value_r  <= '0;
        seg_header_r <= '0;
        has_value_r  <= 1'b0;
        malformed_r  <= 1'b1;
      end
      path_end_r <= in_ch.last_byte;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.seg_value  = seg_value_r;
  assign out_ch.seg_header = seg_header_r;
  assign out_ch.has_value  = has_value_r;
  assign out_ch.path_end   = path_end_r;
  assign out_ch.malformed  = malformed_r;

  // a running segment never passes the last 32-bit value byte
  `CLDU_ASSERT(a_pos_range, (seg_pos_r <= POS_LAST_DWORD), "segment position out of range")
  // a halted path holds no partial segment
  `CLDU_ASSERT(a_halt_pos, (halted_r |-> seg_pos_r == POS_HDR), "halted inside a segment")
  // final byte returns the decoder to reset state
  `CLDU_ASSERT(a_end_clear, (in_acc && in_ch.last_byte |=> seg_pos_r == POS_HDR && !halted_r && hdr_r == '0), "state not cleared at path end")
  // malformed only on an end beat without a value
  `CLDU_ASSERT(a_malformed, (out_vld_r && malformed_r |-> path_end_r && !has_value_r), "malformed beat carries a value")
  // no result beat right after reset
  `CLDU_ASSERT_ALWAYS(a_rst_idle, (!rst_n |=> !out_vld_r), "result valid after reset")

endmodule
